>>> hdl/sld_pkg.sv
package sld_pkg;

  localparam logic [7:0] SyncByte0 = 8'h55;
  localparam logic [7:0] SyncByte1 = 8'hAA;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       chunk_end;
  } req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic       frame_done;
  } res_t;

endpackage

>>> hdl/sld_req_if.sv
interface sld_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       chunk_end;

  modport source (output valid, output byte_value, output chunk_end, input ready);
  modport sink (input valid, input byte_value, input chunk_end, output ready);
endinterface

>>> hdl/sld_res_if.sv
interface sld_res_if;
  logic            valid;
  logic            ready;
  sld_pkg::kind_e  kind;
  logic [7:0]      payload_byte;
  logic            frame_done;

  modport source (output valid, output kind, output payload_byte, output frame_done,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_done,
                output ready);
endinterface

>>> hdl/sld_parser.sv
module sld_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  sld_pkg::req_t req_i,
  output logic          res_valid_o,
  output sld_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_BODY  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic        in_frame;
  logic [7:0]  b;

  assign b = req_i.byte_value;

  always_comb begin
    phase_d     = phase_q;
    len_hi_d    = len_hi_q;
    left_d      = left_q;
    sum_d       = sum_q;
    in_frame    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{kind: sld_pkg::KIND_DATA, payload_byte: 8'h00, frame_done: 1'b0};
    case (phase_q)
      PH_SYNC0: begin
        if (b == sld_pkg::SyncByte0) begin
          sum_d   = b;
          phase_d = PH_SYNC1;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_SYNC1: begin
        if (b == sld_pkg::SyncByte1) begin
          sum_d   = sum_q + b;
          phase_d = PH_LENHI;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_LENHI: begin
        in_frame = 1'b1;
        len_hi_d = b;
        sum_d    = sum_q + b;
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        in_frame = 1'b1;
        left_d   = {len_hi_q, b};
        sum_d    = sum_q + b;
        phase_d  = ({len_hi_q, b} == 16'd0) ? PH_CSUM : PH_BODY;
      end
      PH_BODY: begin
        in_frame = 1'b1;
        sum_d    = sum_q + b;
        left_d   = left_q - 16'd1;
        if (left_q == 16'd1) begin
          phase_d = PH_CSUM;
        end
        if (!req_i.chunk_end) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = b;
        end
      end
      PH_CSUM: begin
        res_valid_o      = 1'b1;
        res_o.kind       = (b == sum_q) ? sld_pkg::KIND_GOOD : sld_pkg::KIND_BAD;
        res_o.frame_done = 1'b1;
        phase_d          = PH_SKIP;
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase

    if (req_i.chunk_end) begin
      if (in_frame) begin
        res_valid_o = 1'b1;
        res_o       = '{kind: sld_pkg::KIND_TRUNC, payload_byte: 8'h00, frame_done: 1'b1};
      end
      phase_d  = PH_SYNC0;
      len_hi_d = 8'h00;
      left_d   = 16'd0;
      sum_d    = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC0;
      len_hi_q <= 8'h00;
      left_q   <= 16'd0;
      sum_q    <= 8'h00;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      sum_q    <= sum_d;
    end
  end

endmodule

>>> hdl/sync_length_checksum_deframer.sv
// frame parser for chunks of received bytes
// req_i: one request per byte, byte_value with chunk_end set on the chunk's
//   last byte; a frame is 0x55 0xaa, a 16-bit big-endian length, the
//   payload and an 8-bit additive checksum over everything before it
// res_o: payload bytes (kind data) as they arrive, then one status per
//   frame (good, checksum error or truncated) with frame_done set
// a request is registered in the input register and parsed there; its result
//   is loaded into the result register, which drives res_o.valid
// one byte per cycle while res_o does not stall; the input register and the result
//   register form a two-stage pipeline with ready chained back from res_o
// bad headers and bytes after the checksum give no result
// a stall on res_o holds the result register; the input register still
//   takes one more request, then req_i.ready drops until res_o drains
// reset clears both pipeline valids and returns the parser to waiting for
//   the first sync byte
module sync_length_checksum_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  sld_req_if.sink   req_i,
  sld_res_if.source res_o
);

  logic          s1_valid_q;
  sld_pkg::req_t s1_req_q;
  logic          out_valid_q;
  sld_pkg::res_t out_res_q;
  logic          out_free;
  logic          step;
  logic          par_valid;
  sld_pkg::res_t par_res;

  assign out_free    = !out_valid_q || res_o.ready;
  assign step        = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || out_free;

  sld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_i       (s1_req_q),
    .res_valid_o (par_valid),
    .res_o       (par_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= step && par_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_req_q <= '{byte_value: req_i.byte_value, chunk_end: req_i.chunk_end};
    end
    if (out_free) begin
      out_res_q <= par_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = out_res_q.kind;
  assign res_o.payload_byte = out_res_q.payload_byte;
  assign res_o.frame_done   = out_res_q.frame_done;

  a_done_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.frame_done == (out_res_q.kind != sld_pkg::KIND_DATA)))
    else $error("frame_done disagrees with kind");

  a_status_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.frame_done) |-> (out_res_q.payload_byte == 8'h00))
    else $error("status result carries a payload byte");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_req_q)))
    else $error("input stage lost a request during a stall");

endmodule

>>> test/deframer_monitor.sv
module deframer_monitor (
  input  logic clk_i,
  input  logic rst_ni,
  sld_req_if   req_mon,
  sld_res_if   res_mon,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   payload_count_o,
  output int   good_count_o,
  output int   bad_count_o,
  output int   trunc_count_o
);

  typedef enum logic [2:0] {
    WAIT_SYNC0, WAIT_SYNC1, LEN_HI, LEN_LO, PAYLOAD, CHECKSUM, SKIP_REST
  } parse_phase_e;

  parse_phase_e  phase_q;
  logic [15:0]   length_q;
  logic [15:0]   left_q;
  logic [7:0]    sum_q;
  sld_pkg::res_t expected_results[$];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count_o++;
  endtask

  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output sld_pkg::res_t res);
    bit in_frame;
    bit has_res;
    in_frame = 1'b0;
    has_res  = 1'b0;
    res      = '0;
    case (phase_q)
      WAIT_SYNC0: begin
        if (b == sld_pkg::SyncByte0) begin
          sum_q   = b;
          phase_q = WAIT_SYNC1;
        end else begin
          phase_q = SKIP_REST;
        end
      end
      WAIT_SYNC1: begin
        if (b == sld_pkg::SyncByte1) begin
          sum_q   = sum_q + b;
          phase_q = LEN_HI;
        end else begin
          phase_q = SKIP_REST;
        end
      end
      LEN_HI: begin
        in_frame = 1'b1;
        length_q = {b, 8'h00};
        sum_q    = sum_q + b;
        phase_q  = LEN_LO;
      end
      LEN_LO: begin
        in_frame = 1'b1;
        length_q = length_q | {8'h00, b};
        left_q   = length_q;
        sum_q    = sum_q + b;
        phase_q  = (left_q == 16'd0) ? CHECKSUM : PAYLOAD;
      end
      PAYLOAD: begin
        in_frame = 1'b1;
        sum_q    = sum_q + b;
        left_q   = left_q - 16'd1;
        if (left_q == 16'd0) phase_q = CHECKSUM;
        if (!last) begin
          res.kind         = sld_pkg::KIND_DATA;
          res.payload_byte = b;
          res.frame_done   = 1'b0;
          has_res          = 1'b1;
        end
      end
      CHECKSUM: begin
        res.kind         = (b == sum_q) ? sld_pkg::KIND_GOOD : sld_pkg::KIND_BAD;
        res.payload_byte = 8'h00;
        res.frame_done   = 1'b1;
        has_res          = 1'b1;
        phase_q          = SKIP_REST;
      end
      default: phase_q = SKIP_REST;
    endcase
    if (last) begin
      if (in_frame) begin
        res.kind         = sld_pkg::KIND_TRUNC;
        res.payload_byte = 8'h00;
        res.frame_done   = 1'b1;
        has_res          = 1'b1;
      end
      phase_q  = WAIT_SYNC0;
      length_q = '0;
      left_q   = '0;
      sum_q    = '0;
    end
    return has_res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sld_pkg::res_t got;
    sld_pkg::res_t want;
    sld_pkg::res_t pred;
    if (!rst_ni) begin
      phase_q  = WAIT_SYNC0;
      length_q = '0;
      left_q   = '0;
      sum_q    = '0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got.kind         = res_mon.kind;
        got.payload_byte = res_mon.payload_byte;
        got.frame_done   = res_mon.frame_done;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h done %0b",
                                    got.kind, got.payload_byte, got.frame_done));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %02h, want %02h",
                                      got.payload_byte, want.payload_byte));
          if (got.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done %0b, want %0b",
                                      got.frame_done, want.frame_done));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (parse_byte(req_mon.byte_value, req_mon.chunk_end, pred)) begin
          expected_results.insert(expected_results.size(), pred);
          case (pred.kind)
            sld_pkg::KIND_DATA: payload_count_o++;
            sld_pkg::KIND_GOOD: good_count_o++;
            sld_pkg::KIND_BAD:  bad_count_o++;
            default:            trunc_count_o++;
          endcase
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> test/testbench.sv
module testbench;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i = 1'b0;
  logic rst_ni;

  sld_req_if req_if();
  sld_res_if res_if();

  int mismatch_count;
  int pending_count;
  int payload_count;
  int good_count;
  int bad_count;
  int trunc_count;
  int sent_count;
  int res_seen;
  int stall_left;
  bit src_idle;
  bit snk_idle;

  sync_length_checksum_deframer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  deframer_monitor frame_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_if),
    .res_mon          (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count),
    .payload_count_o  (payload_count),
    .good_count_o     (good_count),
    .bad_count_o      (bad_count),
    .trunc_count_o    (trunc_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // downstream stall, drawn per result
  always @(posedge clk_i) begin
    int k;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (res_if.valid && res_if.ready) begin
      res_seen++;
      if (res_seen % 40 == 0) snk_idle = ($urandom_range(0, 3) != 0);
      k = snk_idle ? $urandom_range(0, 6) : 0;
      stall_left   <= k;
      res_if.ready <= (k == 0);
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.byte_value <= b;
    req_if.chunk_end  <= last;
    @(negedge clk_i);
    while (!req_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    sent_count++;
    if (sent_count % 50 == 0) src_idle = ($urandom_range(0, 3) != 0);
  endtask

  task automatic send_chunk(input byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // header, length field, the first body_n payload bytes, then checksum and trailer if body_n equals len
  function automatic byte_q_t build_frame(input logic [15:0] len, input int body_n,
                                          input bit sum_ok, input int trail);
    byte_q_t     q;
    logic [7:0]  sum;
    logic [7:0]  b;
    q   = '{sld_pkg::SyncByte0, sld_pkg::SyncByte1, len[15:8], len[7:0]};
    sum = sld_pkg::SyncByte0 + sld_pkg::SyncByte1 + len[15:8] + len[7:0];
    for (int i = 0; i < body_n; i++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum + b;
      q.insert(q.size(), b);
    end
    if (body_n == len) begin
      q.insert(q.size(), sum_ok ? sum : sum ^ 8'($urandom_range(1, 255)));
      for (int i = 0; i < trail; i++) q.insert(q.size(), 8'($urandom_range(0, 255)));
    end
    return q;
  endfunction

  task automatic send_random_chunk();
    byte_q_t     q;
    int          pick;
    int          body_n;
    logic [15:0] len;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 40))
                                         : 16'($urandom_range(0, 12));
      q = build_frame(len, len, $urandom_range(0, 99) < 65,
                      $urandom_range(0, 1) ? $urandom_range(1, 3) : 0);
    end else if (pick < 80) begin
      len = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 12));
      body_n = (len > 12) ? 12 : len;
      q = build_frame(len, body_n, 1'b1, 0);
      while (q.size() > 4 + body_n) void'(q.pop_back());
      while (q.size() > $urandom_range(3, 4 + body_n)) void'(q.pop_back());
    end else if (pick < 90) begin
      q = '{sld_pkg::SyncByte0};
      if ($urandom_range(0, 3) != 0) begin
        b = 8'($urandom_range(0, 255));
        if (b == sld_pkg::SyncByte1) b = ~b;
        q.insert(q.size(), b);
        repeat ($urandom_range(0, 3)) q.insert(q.size(), 8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 5)) q.insert(q.size(), 8'($urandom_range(0, 255)));
    end
    send_chunk(q);
  endtask

  initial begin
    byte_q_t q;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.byte_value = 8'h00;
    req_if.chunk_end  = 1'b0;
    src_idle          = 1'b1;
    snk_idle          = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // good zero-length frame
    q = '{8'h55, 8'hAA, 8'h00, 8'h00, 8'hFF};
    send_chunk(q);
    // checksum error on a one-byte payload, then a trailing byte
    q = '{8'h55, 8'hAA, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00};
    send_chunk(q);
    // wrong first byte, wrong second byte, chunk ending inside sync
    q = '{8'h00};
    send_chunk(q);
    q = '{8'h55, 8'h00};
    send_chunk(q);
    q = '{8'h55};
    send_chunk(q);
    // truncated on the length high byte and inside the payload
    q = '{8'h55, 8'hAA, 8'hFF};
    send_chunk(q);
    q = '{8'h55, 8'hAA, 8'h00, 8'h02, 8'h12, 8'h34};
    send_chunk(q);

    while (sent_count < 850) send_random_chunk();
    req_if.valid <= 1'b0;

    do @(negedge clk_i); while (pending_count != 0);
    repeat (20) @(negedge clk_i);

    $display("sent %0d requests in chunks: %0d payload bytes streamed", sent_count,
             payload_count);
    $display("frames: %0d good, %0d checksum errors, %0d truncated", good_count, bad_count,
             trunc_count);
    if (mismatch_count == 0) begin
      $display("sync_length_checksum_deframer verification clean");
    end else begin
      $display("sync_length_checksum_deframer verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sync_length_checksum_deframer verification failed");
    $finish;
  end

endmodule
